@@ rtl/tfcp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_pkg
// Shared types, constants and functions for the type A framing core.
// ----------------------------------------------------------------------------
package tfcp_pkg;

   localparam int MaxResults = 3;

   localparam logic [15:0] CrcPreset = 16'h6363;
   localparam logic [15:0] CrcPoly   = 16'h8408;

   localparam logic ActTransmit = 1'b0;
   localparam logic ActReceive  = 1'b1;

   localparam logic [1:0] VerdictNone   = 2'd0;
   localparam logic [1:0] VerdictGood   = 2'd1;
   localparam logic [1:0] VerdictParity = 2'd2;
   localparam logic [1:0] VerdictCrc    = 2'd3;

   localparam logic [1:0] CountSat = 2'd3;

   typedef struct packed {
      logic [8:0] symbol;
      logic       end_of_run;
      logic [1:0] verdict;
   } rsp_item_type;

   typedef struct packed {
      rsp_item_type [MaxResults-1:0] item;
      logic [1:0]                    count;
   } batch_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic [8:0] with_odd(input logic [7:0] b);
      return {~^b, b};
   endfunction

endpackage

@@ rtl/tfcp_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_req_if
// Input channel: one byte or 9-bit symbol per item.
// ----------------------------------------------------------------------------
interface tfcp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [8:0] data;
   logic       last;

   modport source (output valid, output action, output data, output last, input ready);
   modport sink   (input valid, input action, input data, input last, output ready);
endinterface

@@ rtl/tfcp_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_rsp_if
// Result channel: symbols, decoded bytes and frame verdicts.
// ----------------------------------------------------------------------------
interface tfcp_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] symbol;
   logic       end_of_run;
   logic [1:0] verdict;

   modport source (output valid, output symbol, output end_of_run, output verdict,
                   input ready);
   modport sink   (input valid, input symbol, input end_of_run, input verdict,
                   output ready);
endinterface

@@ rtl/tfcp_frame_calc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_frame_calc
// Frame state (CRC, parity flag, byte count) and per-item result batch.
// ----------------------------------------------------------------------------
module tfcp_frame_calc (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                action,
   input  logic [8:0]          data,
   input  logic                last,
   output tfcp_pkg::batch_type batch
);

   logic [15:0] crc_ff, crc_in;
   logic        pfail_ff, pfail_in;
   logic [1:0]  count_ff, count_in;

   logic [7:0]  b;
   logic [15:0] crc_next;
   logic        pfail_next;
   logic [1:0]  count_next;
   logic [1:0]  verdict;

   assign b          = data[7:0];
   assign crc_next   = tfcp_pkg::crc_update(crc_ff, b);
   assign pfail_next = pfail_ff | ((action == tfcp_pkg::ActReceive) & ~(^data));
   assign count_next = (count_ff == tfcp_pkg::CountSat) ? count_ff : count_ff + 2'd1;

   always_comb begin
      priority if (pfail_next) begin
         verdict = tfcp_pkg::VerdictParity;
      end else if (count_next <= 2'd2 || crc_next != 16'h0000) begin
         verdict = tfcp_pkg::VerdictCrc;
      end else begin
         verdict = tfcp_pkg::VerdictGood;
      end
   end

   always_comb begin
      batch = '0;
      if (action == tfcp_pkg::ActTransmit) begin
         batch.item[0].symbol = tfcp_pkg::with_odd(b);
         if (last) begin
            batch.item[1].symbol     = tfcp_pkg::with_odd(crc_next[7:0]);
            batch.item[2].symbol     = tfcp_pkg::with_odd(crc_next[15:8]);
            batch.item[2].end_of_run = 1'b1;
            batch.count              = 2'd3;
         end else begin
            batch.item[0].end_of_run = 1'b1;
            batch.count              = 2'd1;
         end
      end else begin
         batch.item[0].symbol = {1'b0, b};
         if (last) begin
            batch.item[1].end_of_run = 1'b1;
            batch.item[1].verdict    = verdict;
            batch.count              = 2'd2;
         end else begin
            batch.item[0].end_of_run = 1'b1;
            batch.count              = 2'd1;
         end
      end
   end

   always_comb begin
      crc_in   = crc_ff;
      pfail_in = pfail_ff;
      count_in = count_ff;
      if (load) begin
         if (last) begin
            crc_in   = tfcp_pkg::CrcPreset;
            pfail_in = 1'b0;
            count_in = 2'd0;
         end else begin
            crc_in   = crc_next;
            pfail_in = pfail_next;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= tfcp_pkg::CrcPreset;
         pfail_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         crc_ff   <= crc_in;
         pfail_ff <= pfail_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/tfcp_rsp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfcp_rsp_queue
// Result register holding one batch of up to three items, drained in order.
// ----------------------------------------------------------------------------
module tfcp_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  tfcp_pkg::batch_type batch,
   output logic                can_load,
   tfcp_rsp_if.source          rsp
);

   tfcp_pkg::rsp_item_type ent_ff [tfcp_pkg::MaxResults];
   tfcp_pkg::rsp_item_type ent_in [tfcp_pkg::MaxResults];
   logic [1:0] rem_ff, rem_in;
   logic [1:0] ptr_ff, ptr_in;
   logic       pop;

   assign rsp.valid      = (rem_ff != 2'd0);
   assign rsp.symbol     = ent_ff[ptr_ff].symbol;
   assign rsp.end_of_run = ent_ff[ptr_ff].end_of_run;
   assign rsp.verdict    = ent_ff[ptr_ff].verdict;

   assign pop      = rsp.valid & rsp.ready;
   assign can_load = (rem_ff == 2'd0) | ((rem_ff == 2'd1) & rsp.ready);

   always_comb begin
      ent_in = ent_ff;
      rem_in = rem_ff;
      ptr_in = ptr_ff;
      priority if (load) begin
         for (int i = 0; i < tfcp_pkg::MaxResults; i++) begin
            ent_in[i] = batch.item[i];
         end
         rem_in = batch.count;
         ptr_in = 2'd0;
      end else if (pop) begin
         rem_in = rem_ff - 2'd1;
         ptr_in = ptr_ff + 2'd1;
      end else begin
         rem_in = rem_ff;
         ptr_in = ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
         ptr_ff <= 2'd0;
      end else begin
         rem_ff <= rem_in;
         ptr_ff <= ptr_in;
      end
   end

endmodule

@@ rtl/typea_frame_crc_parity_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typea_frame_crc_parity_core
// Type A byte framing: odd parity per byte and CRC_A over the frame.
//
// req_chan carries one item: action (0 transmit byte, 1 receive 9-bit
// symbol), data and last. rsp_chan returns the results of each item in
// order; end_of_run marks the final result of an item.
// Transmit byte: one symbol with odd parity; on last, two CRC symbols follow
// (low byte first). Receive symbol: the decoded byte; on last, a verdict
// item follows (parity error, CRC error or frame good).
// Path: an accepted item is held in the input register until the result
// register has room, then loaded as a batch that shows its first result.
// Throughput: one item per cycle while each item yields a single result
// and the receiver is ready; the three-item result register drains one
// result per ready cycle. A transmit last gives 3 results, a receive last 2.
// Reset clears the frame state (CRC preset, parity flag, byte count) and
// drops any held item or result. When the receiver stalls, the result
// register holds and the input register takes one more item, then
// req_chan.ready drops. Frame state restarts after every last item.
// ----------------------------------------------------------------------------
module typea_frame_crc_parity_core (
   input  logic        clock,
   input  logic        reset,
   tfcp_req_if.sink    req_chan,
   tfcp_rsp_if.source  rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic       action_ff, action_in;
   logic [8:0] data_ff, data_in;
   logic       last_ff, last_in;
   logic       req_acc;
   logic       load;
   logic       can_load;

   tfcp_pkg::batch_type batch;

   assign load           = in_valid_ff & can_load;
   assign req_chan.ready = ~in_valid_ff | load;
   assign req_acc        = req_chan.valid & req_chan.ready;
   assign in_valid_in    = req_acc | (in_valid_ff & ~load);

   always_comb begin
      action_in = action_ff;
      data_in   = data_ff;
      last_in   = last_ff;
      if (req_acc) begin
         action_in = req_chan.action;
         data_in   = req_chan.data;
         last_in   = req_chan.last;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      data_ff   <= data_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   tfcp_frame_calc u_calc (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .action (action_ff),
      .data   (data_ff),
      .last   (last_ff),
      .batch  (batch)
   );

   tfcp_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .batch    (batch),
      .can_load (can_load),
      .rsp      (rsp_chan)
   );

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load) |-> !req_acc)
      else $error("input register overwritten while held");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_chan.valid)
      else $error("loaded batch not presented");

   a_verdict_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.verdict != tfcp_pkg::VerdictNone)
         |-> (rsp_chan.end_of_run && rsp_chan.symbol == 9'h000))
      else $error("verdict item not final or has a symbol");

   a_load_room: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_chan.valid) |-> rsp_chan.ready)
      else $error("batch loaded over a pending result");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the type A framing core: odd parity on transmit bytes, CRC_A
// trailer on the last transmit byte, parity check and frame verdict on
// receive. A table of directed items comes first, then random frames
// (transmit frames, receive frames with a correct CRC trailer, some
// corrupted, short receive frames without one, some noise) under several
// phases of sender and receiver idling. Each result is compared with its
// typed table row or a cycle-free model of the frame state in this file.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct packed {
      logic                             act;
      logic [8:0]                       data;
      logic                             lst;
      logic [1:0]                       nk;
      tfcp_pkg::rsp_item_type [2:0]     kr;
   } stim_row_type;

   localparam tfcp_pkg::rsp_item_type NoItem = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tfcp_req_if req_chan ();
   tfcp_rsp_if rsp_chan ();

   typea_frame_crc_parity_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   logic [15:0]            frame_crc;
   logic                   frame_parity_bad;
   logic [1:0]             frame_bytes;
   tfcp_pkg::rsp_item_type pending_rsp [$];
   stim_row_type           dir_tab [$];

   int idle_pct;
   int stall_pct;
   int errors;
   int items_in;
   int rsp_checked;
   int n_good;
   int n_parity;
   int n_crc;
   tfcp_pkg::rsp_item_type got;
   tfcp_pkg::rsp_item_type want;

   function automatic logic [15:0] crc_a_next(input logic [15:0] crc, input logic [7:0] b);
      logic [7:0] ch;
      ch = b ^ crc[7:0];
      ch = ch ^ (ch << 4);
      return (crc >> 8) ^ {ch, 8'h00} ^ ({8'h00, ch} << 3) ^ {12'h000, ch[7:4]};
   endfunction

   function automatic logic [8:0] odd_sym(input logic [7:0] b);
      logic p;
      p = 1'b1;
      for (int k = 0; k < 8; k++) p = p ^ b[k];
      return {p, b};
   endfunction

   function automatic tfcp_pkg::rsp_item_type mk(input logic [8:0] sym, input logic eor,
                                                 input logic [1:0] ver);
      tfcp_pkg::rsp_item_type r;
      r.symbol     = sym;
      r.end_of_run = eor;
      r.verdict    = ver;
      return r;
   endfunction

   function automatic stim_row_type row(input logic act, input logic [8:0] data,
                                        input logic lst, input logic [1:0] nk,
                                        input tfcp_pkg::rsp_item_type k0,
                                        input tfcp_pkg::rsp_item_type k1,
                                        input tfcp_pkg::rsp_item_type k2);
      stim_row_type r;
      r.act   = act;
      r.data  = data;
      r.lst   = lst;
      r.nk    = nk;
      r.kr[0] = k0;
      r.kr[1] = k1;
      r.kr[2] = k2;
      return r;
   endfunction

   function automatic void frame_restart();
      frame_crc        = tfcp_pkg::CrcPreset;
      frame_parity_bad = 1'b0;
      frame_bytes      = '0;
   endfunction

   function automatic void frame_take(input logic [7:0] b);
      frame_crc = crc_a_next(frame_crc, b);
      if (frame_bytes != tfcp_pkg::CountSat) frame_bytes = frame_bytes + 2'd1;
   endfunction

   // typed rows replace the computed results, the frame state still advances
   function automatic void predict_item(input stim_row_type r);
      tfcp_pkg::rsp_item_type calc [$];
      logic [7:0]   b;
      logic [1:0]   v;
      b = r.data[7:0];
      if (r.act == tfcp_pkg::ActTransmit) begin
         frame_take(b);
         if (!r.lst) begin
            calc.push_back(mk(odd_sym(b), 1'b1, tfcp_pkg::VerdictNone));
         end else begin
            calc.push_back(mk(odd_sym(b), 1'b0, tfcp_pkg::VerdictNone));
            calc.push_back(mk(odd_sym(frame_crc[7:0]), 1'b0, tfcp_pkg::VerdictNone));
            calc.push_back(mk(odd_sym(frame_crc[15:8]), 1'b1, tfcp_pkg::VerdictNone));
            frame_restart();
         end
      end else begin
         if (!(^r.data)) frame_parity_bad = 1'b1;
         frame_take(b);
         if (!r.lst) begin
            calc.push_back(mk({1'b0, b}, 1'b1, tfcp_pkg::VerdictNone));
         end else begin
            if (frame_parity_bad) v = tfcp_pkg::VerdictParity;
            else if (frame_bytes <= 2'd2 || frame_crc != 16'h0000) v = tfcp_pkg::VerdictCrc;
            else v = tfcp_pkg::VerdictGood;
            calc.push_back(mk({1'b0, b}, 1'b0, tfcp_pkg::VerdictNone));
            calc.push_back(mk(9'h000, 1'b1, v));
            frame_restart();
         end
      end
      if (r.nk != 0) begin
         calc = {};
         for (int k = 0; k < r.nk; k++) calc.push_back(r.kr[k]);
      end
      foreach (calc[k]) pending_rsp.push_back(calc[k]);
   endfunction

   task automatic send_item(input stim_row_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= r.act;
      req_chan.data   <= r.data;
      req_chan.last   <= r.lst;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(r);
      items_in++;
   endtask

   task automatic send_random_frame();
      int         kind;
      int         len;
      int         pick;
      logic [15:0] c;
      logic [7:0] b;
      logic       act;
      logic [8:0] syms [$];
      kind = $urandom_range(99);
      act  = tfcp_pkg::ActReceive;
      if (kind < 22) begin
         act = tfcp_pkg::ActTransmit;
         len = $urandom_range(1, 6);
         for (int k = 0; k < len; k++) syms.push_back(9'($urandom_range(511)));
      end else if (kind < 80) begin
         len = $urandom_range(1, 5);
         c   = tfcp_pkg::CrcPreset;
         for (int k = 0; k < len; k++) begin
            b = 8'($urandom_range(255));
            c = crc_a_next(c, b);
            syms.push_back(odd_sym(b));
         end
         syms.push_back(odd_sym(c[7:0]));
         syms.push_back(odd_sym(c[15:8]));
         if (kind >= 66) begin
            pick = $urandom_range(syms.size() - 1);
            if ($urandom_range(1)) syms[pick][8] = ~syms[pick][8];
            else syms[pick] = odd_sym(syms[pick][7:0] ^ (8'h01 << $urandom_range(7)));
         end
      end else if (kind < 88) begin
         len = $urandom_range(1, 2);
         for (int k = 0; k < len; k++) syms.push_back(odd_sym(8'($urandom_range(255))));
      end
      if (kind >= 88) begin
         len = $urandom_range(1, 4);
         for (int k = 0; k < len; k++)
            send_item(row(1'($urandom_range(1)), 9'($urandom_range(511)),
                          ($urandom_range(3) == 0), 2'd0, NoItem, NoItem, NoItem));
      end else begin
         foreach (syms[k])
            send_item(row(act, syms[k], (k == syms.size() - 1), 2'd0,
                          NoItem, NoItem, NoItem));
      end
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = mk(rsp_chan.symbol, rsp_chan.end_of_run, rsp_chan.verdict);
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: expected none, actual sym %h eor %b ver %0d",
                     $time, got.symbol, got.end_of_run, got.verdict);
         end else begin
            want = pending_rsp.pop_front();
            rsp_checked++;
            case (want.verdict)
               tfcp_pkg::VerdictGood:   n_good++;
               tfcp_pkg::VerdictParity: n_parity++;
               tfcp_pkg::VerdictCrc:    n_crc++;
               default: ;
            endcase
            if (got.symbol !== want.symbol || got.end_of_run !== want.end_of_run ||
                got.verdict !== want.verdict) begin
               errors++;
               $display({"%0t: mismatch: expected sym %h eor %b ver %0d, ",
                         "actual sym %h eor %b ver %0d"},
                        $time, want.symbol, want.end_of_run, want.verdict,
                        got.symbol, got.end_of_run, got.verdict);
            end
         end
      end
   end

   initial begin
      #200000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      req_chan.valid  = 1'b0;
      req_chan.action = tfcp_pkg::ActTransmit;
      req_chan.data   = '0;
      req_chan.last   = 1'b0;
      rsp_chan.ready  = 1'b0;
      idle_pct    = 0;
      stall_pct   = 0;
      errors      = 0;
      items_in    = 0;
      rsp_checked = 0;
      n_good      = 0;
      n_parity    = 0;
      n_crc       = 0;
      frame_restart();

      // transmit: extremes, parity bit on input ignored, known CRC of two zero bytes
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h000, 1'b0, 2'd1,
                            mk(9'h100, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h0FF, 1'b0, 2'd1,
                            mk(9'h1FF, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h17F, 1'b1, 2'd0,
                            NoItem, NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h000, 1'b0, 2'd1,
                            mk(9'h100, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h000, 1'b1, 2'd3,
                            mk(9'h100, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h1A0, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h11E, 1'b1, tfcp_pkg::VerdictNone)));
      // receive: good frame, single bad parity, single byte, parity beats CRC
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h100, 1'b0, 2'd1,
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h100, 1'b0, 2'd1,
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h1A0, 1'b0, 2'd1,
                            mk(9'h0A0, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h11E, 1'b1, 2'd2,
                            mk(9'h01E, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictGood), NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h000, 1'b1, 2'd2,
                            mk(9'h000, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictParity), NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h1FF, 1'b1, 2'd2,
                            mk(9'h0FF, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictCrc), NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h1FF, 1'b0, 2'd1,
                            mk(9'h0FF, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h180, 1'b0, 2'd1,
                            mk(9'h080, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h101, 1'b1, 2'd2,
                            mk(9'h001, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictParity), NoItem));
      // two-byte frame with zero residue still fails on length
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h163, 1'b0, 2'd1,
                            mk(9'h063, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h163, 1'b1, 2'd2,
                            mk(9'h063, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictCrc), NoItem));
      // mixed directions share one frame state
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h000, 1'b0, 2'd1,
                            mk(9'h100, 1'b1, tfcp_pkg::VerdictNone), NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h100, 1'b0, 2'd0,
                            NoItem, NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h1A0, 1'b0, 2'd0,
                            NoItem, NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h11E, 1'b1, 2'd2,
                            mk(9'h01E, 1'b0, tfcp_pkg::VerdictNone),
                            mk(9'h000, 1'b1, tfcp_pkg::VerdictGood), NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActReceive, 9'h155, 1'b0, 2'd0,
                            NoItem, NoItem, NoItem));
      dir_tab.push_back(row(tfcp_pkg::ActTransmit, 9'h0AA, 1'b1, 2'd0,
                            NoItem, NoItem, NoItem));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k]) send_item(dir_tab[k]);
      @(negedge clock);
      req_chan.valid <= 1'b0;
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 48; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 48; end
            default: begin idle_pct = 14; stall_pct = 14; end
         endcase
         for (int start = items_in; items_in - start < 24; ) send_random_frame();
         @(negedge clock);
         req_chan.valid <= 1'b0;
         drain();
      end

      repeat (10) @(posedge clock);
      $display("summary: %0d items sent, %0d results checked", items_in, rsp_checked);
      $display("summary: verdicts good %0d, parity %0d, crc %0d", n_good, n_parity, n_crc);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
